@@ design/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  // Most results one input item can cause.
  localparam int REC_BYTES = 4;
  localparam int REC_IDX_W = $clog2(REC_BYTES);

  // Default number of records the queue between front and back holds.
  localparam int QUEUE_DEPTH_DEF = 4;

  // One classified item: the results it causes, ready to be played out.
  typedef struct packed {
    logic [REC_BYTES-1:0][7:0] bytes;
    logic [REC_IDX_W-1:0]      last_idx;
    logic                      has;
    logic                      fin;
  } rec_t;

endpackage

@@ design/jsu_front.sv @@
// Front end: escape state machine turning each item into at most one result record.
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output rec_t       rec
);

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_HEX   = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] UTF_LEAD2 = 8'hc0;
  localparam logic [7:0] UTF_LEAD3 = 8'he0;
  localparam logic [7:0] UTF_CONT  = 8'h80;
  localparam logic [5:0] UTF_MASK  = 6'h3f;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else begin
      v = 8'h00;
    end
    hex_val = v[3:0];
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    case (c)
      8'h62:   esc_map = 8'h08;
      8'h66:   esc_map = 8'h0c;
      8'h6e:   esc_map = 8'h0a;
      8'h72:   esc_map = 8'h0d;
      8'h74:   esc_map = 8'h09;
      default: esc_map = c;
    endcase
  endfunction

  logic [1:0]      mode, mode_next;
  logic [1:0]      cnt, cnt_next;
  logic [2:0][7:0] held, held_next;
  logic [15:0]     cp;
  logic [2:0]      n;
  logic            do_plain;

  assign cp = {hex_val(held[0]), hex_val(held[1]), hex_val(held[2]), hex_val(in_byte)};

  always_comb begin
    rec       = '0;
    n         = 3'd0;
    mode_next = mode;
    cnt_next  = cnt;
    held_next = held;
    do_plain  = 1'b0;

    case (mode)
      MODE_ESC: begin
        if (in_byte == CH_U) begin
          mode_next = MODE_HEX;
          cnt_next  = 2'd0;
        end else begin
          rec.bytes[n[1:0]] = esc_map(in_byte);
          n = n + 3'd1;
          mode_next = MODE_PLAIN;
        end
      end
      MODE_HEX: begin
        if (!is_hex(in_byte)) begin
          // Drop the u, replay the held digits, then treat the byte as plain.
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < cnt) begin
              rec.bytes[n[1:0]] = held[k];
              n = n + 3'd1;
            end
          end
          cnt_next = 2'd0;
          do_plain = 1'b1;
        end else if (cnt == 2'd3) begin
          mode_next = MODE_PLAIN;
          cnt_next  = 2'd0;
          if (cp[15:7] == 9'd0) begin
            rec.bytes[0] = {1'b0, cp[6:0]};
            n = 3'd1;
          end else if (cp[15:11] == 5'd0) begin
            rec.bytes[0] = UTF_LEAD2 | {3'b000, cp[10:6]};
            rec.bytes[1] = UTF_CONT | {2'b00, cp[5:0] & UTF_MASK};
            n = 3'd2;
          end else begin
            rec.bytes[0] = UTF_LEAD3 | {4'b0000, cp[15:12]};
            rec.bytes[1] = UTF_CONT | {2'b00, cp[11:6] & UTF_MASK};
            rec.bytes[2] = UTF_CONT | {2'b00, cp[5:0] & UTF_MASK};
            n = 3'd3;
          end
        end else begin
          held_next[cnt] = in_byte;
          cnt_next = cnt + 2'd1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (in_byte == CH_BSLASH && !in_last) begin
        mode_next = MODE_ESC;
      end else begin
        rec.bytes[n[1:0]] = in_byte;
        n = n + 3'd1;
        mode_next = MODE_PLAIN;
      end
    end

    if (in_last) begin
      // Short hex run at string end: drop the u and replay what was held.
      if (mode_next == MODE_HEX) begin
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < cnt_next) begin
            rec.bytes[n[1:0]] = held_next[k];
            n = n + 3'd1;
          end
        end
      end
      mode_next = MODE_PLAIN;
      cnt_next  = 2'd0;
    end

    rec.has      = (n != 3'd0);
    rec.last_idx = (n == 3'd0) ? '0 : REC_IDX_W'(n - 3'd1);
    rec.fin      = in_last;
  end

  assign push = accept && (n != 3'd0 || in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      cnt  <= 2'd0;
    end else if (accept) begin
      mode <= mode_next;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

endmodule

@@ design/jsu_queue.sv @@
// Small record queue between the front and back ends.
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  rec_t wr_data,
  output logic full,
  input  logic rd_en,
  output rec_t rd_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  rec_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ design/jsu_back.sv @@
// Back end: plays one record out as a run of result items.
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  rec_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       string_end
);

  rec_t                 cur;
  logic [REC_IDX_W-1:0] idx;
  logic                 busy;
  logic                 fire, done;

  assign out_valid  = busy;
  assign out_byte   = cur.bytes[idx];
  assign has_byte   = cur.has;
  assign run_last   = (idx == cur.last_idx);
  assign string_end = run_last && cur.fin;

  assign fire  = busy && !out_stall;
  assign done  = fire && run_last;
  assign q_pop = !q_empty && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (fire) begin
      idx <= idx + REC_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

endmodule

@@ design/json_string_unescape_utf8.sv @@
// Top level of the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

// Takes the body of a JSON string one byte per item and gives back the
// decoded bytes, one result item per cycle while out_stall is low. Simple
// escapes map to one byte, backslash u with four hex digits becomes 1 to 3
// UTF-8 bytes, and broken or short hex runs replay their digits. Each input
// item is classified combinationally by the front end and accepted every
// cycle while the record queue (QUEUE_DEPTH entries) has room; items that
// produce nothing, such as a backslash or a held hex digit, enter the queue
// only when they close the string. The back end emits one result per cycle
// while out_stall is low, so an item takes one output per result it causes
// (1 to 4), and the queue absorbs those bursts. With the back end idle, an
// accepted item's record is written into the queue and then loaded into the
// back end before its first result is on the outputs. run_last marks the
// final result of each item; string_end marks the final result of the string,
// and a closing item with no byte gives one result with has_byte low.
module json_string_unescape_utf8 import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       string_end
);

  logic accept;
  logic push, q_full, q_empty, q_pop;
  rec_t rec, q_data;

  // Hold input while the queue is full; the front never waits otherwise.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push),
    .rec     (rec)
  );

  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (rec),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

@@ design/jsu_checker.sv @@
// Port-level checks for the JSON string unescaper, bound to the top level.
`timescale 1ns / 1ps

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       run_last,
  input logic       string_end
);

  // The string end always closes an item's run.
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("string_end without run_last");

  // A result without a byte only closes a string, and carries zero.
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> string_end && out_byte == 8'h00)
    else $error("empty result not at string end");

  // Results of one item come out without a gap.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid)
    else $error("gap inside an item's results");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
    $stable(run_last) && $stable(string_end))
    else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .has_byte   (has_byte),
  .run_last   (run_last),
  .string_end (string_end)
);
